@@ design/median_heat_rise_detector_unit_macros.svh @@
// ----------------------------------------------------------------------------
// median_heat_rise_detector_unit_macros.svh
// Assertion macros shared by the median heat rise detector.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_HEAT_RISE_DETECTOR_UNIT_MACROS_SVH
`define MEDIAN_HEAT_RISE_DETECTOR_UNIT_MACROS_SVH

// same-cycle implication
`define MHRD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MHRD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/mhrd_pkg.sv @@
// ----------------------------------------------------------------------------
// mhrd_pkg
// Constants, types and helpers for the median heat rise detector.
// ----------------------------------------------------------------------------
package mhrd_pkg;

   localparam int MEDIAN_TAPS   = 5;
   localparam int HISTORY_DEPTH = 30;
   localparam int SAMPLE_BITS   = 16;

   localparam int TAP_W      = $clog2(MEDIAN_TAPS + 1);
   localparam int RANK_W     = $clog2(MEDIAN_TAPS);
   localparam int MEDIAN_MID = (MEDIAN_TAPS - 1) / 2;
   localparam int CNT_W      = $clog2(HISTORY_DEPTH + 1);

   localparam int MED_W      = 16;
   localparam int COUNT_W    = 5;
   localparam int COUNT_MAX  = (1 << COUNT_W) - 1;
   localparam int THR_W      = 16;
   localparam int NEED_W     = 5;
   localparam int RISE_W     = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;

   localparam int CMP_W  = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
   localparam int DIFF_W = ((SAMPLE_BITS > RISE_W) ? SAMPLE_BITS : RISE_W) + 2;

   localparam logic signed [THR_W-1:0] HIGH_TEMP_RESET  = THR_W'(58);
   localparam logic [NEED_W-1:0]       HIGH_COUNT_RESET = NEED_W'(27);
   localparam logic [RISE_W-1:0]       RISE_RESET       = RISE_W'(8);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HIGH_TEMP  = 2'd0,
      CSR_HIGH_COUNT = 2'd1,
      CSR_RISE       = 2'd2
   } csr_index_type;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      logic signed [THR_W-1:0] high_temp;
      logic [NEED_W-1:0]       need;
      logic [RISE_W-1:0]       rise;
   } cfg_type;

   typedef struct packed {
      logic       vld;
      logic       median_vld;
      sample_type median;
   } push_type;

   typedef struct packed {
      logic [HISTORY_DEPTH-1:0] high;
      logic                     full;
      sample_type               newest;
      sample_type               oldest;
   } hist_view_type;

   function automatic logic at_or_above(sample_type s, logic signed [THR_W-1:0] t);
      logic signed [CMP_W-1:0] a;
      logic signed [CMP_W-1:0] b;
      a = CMP_W'(s);
      b = CMP_W'(t);
      return a >= b;
   endfunction

endpackage

@@ design/mhrd_window.sv @@
// ----------------------------------------------------------------------------
// mhrd_window
// Sample window shift register, fill count and rank-select median.
// ----------------------------------------------------------------------------
module mhrd_window import mhrd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  sample_type temperature,
   input  logic       advance,
   output push_type   push
);

   sample_type        win_ff [MEDIAN_TAPS];
   logic [TAP_W-1:0]  fill_ff;
   logic [TAP_W-1:0]  fill_in;
   logic [RANK_W-1:0] rank [MEDIAN_TAPS];
   sample_type        median;

   always_ff @(posedge clock) begin
      if (load) begin
         win_ff[0] <= temperature;
         for (int i = 1; i < MEDIAN_TAPS; i++) begin
            win_ff[i] <= win_ff[i-1];
         end
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (load && (fill_ff != TAP_W'(MEDIAN_TAPS))) begin
         fill_in = fill_ff + TAP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // ties broken by tap position so every rank is unique
   always_comb begin
      for (int i = 0; i < MEDIAN_TAPS; i++) begin
         rank[i] = '0;
         for (int j = 0; j < MEDIAN_TAPS; j++) begin
            if ((j != i) && ((win_ff[j] < win_ff[i]) ||
                             ((win_ff[j] == win_ff[i]) && (j < i)))) begin
               rank[i] = rank[i] + RANK_W'(1);
            end
         end
      end
   end

   always_comb begin
      median = '0;
      for (int i = 0; i < MEDIAN_TAPS; i++) begin
         if (rank[i] == RANK_W'(MEDIAN_MID)) begin
            median = win_ff[i];
         end
      end
   end

   assign push.vld        = advance;
   assign push.median_vld = (fill_ff == TAP_W'(MEDIAN_TAPS));
   assign push.median     = median;

endmodule

@@ design/mhrd_history.sv @@
// ----------------------------------------------------------------------------
// mhrd_history
// Median history shift register with entry valid bits and high flags.
// ----------------------------------------------------------------------------
module mhrd_history import mhrd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  push_type                push,
   input  logic signed [THR_W-1:0] high_temp,
   output hist_view_type           view
);

   sample_type               hist_ff [HISTORY_DEPTH];
   sample_type               hist_in [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] hvld_ff;
   logic [HISTORY_DEPTH-1:0] hvld_in;
   logic [HISTORY_DEPTH-1:0] high_ff;
   logic [HISTORY_DEPTH-1:0] high_in;
   logic                     push_en;

   assign push_en = push.vld && push.median_vld;

   // flags refresh every cycle so a new threshold takes effect when idle
   always_comb begin
      hist_in[0] = push_en ? push.median : hist_ff[0];
      hvld_in[0] = push_en ? 1'b1 : hvld_ff[0];
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
         hist_in[i] = push_en ? hist_ff[i-1] : hist_ff[i];
         hvld_in[i] = push_en ? hvld_ff[i-1] : hvld_ff[i];
      end
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         high_in[i] = hvld_in[i] && at_or_above(hist_in[i], high_temp);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         hist_ff[i] <= hist_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hvld_ff <= '0;
         high_ff <= '0;
      end else begin
         hvld_ff <= hvld_in;
         high_ff <= high_in;
      end
   end

   assign view.high   = high_ff;
   assign view.full   = hvld_ff[HISTORY_DEPTH-1];
   assign view.newest = hist_ff[0];
   assign view.oldest = hist_ff[HISTORY_DEPTH-1];

endmodule

@@ design/mhrd_result.sv @@
// ----------------------------------------------------------------------------
// mhrd_result
// High count, fixed and rise checks, alarm latch and result register.
// ----------------------------------------------------------------------------
module mhrd_result import mhrd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  push_type                 item,
   input  hist_view_type            view,
   input  cfg_type                  cfg,
   input  logic                     ready,
   output logic                     valid,
   output logic                     median_valid,
   output logic signed [MED_W-1:0]  median_value,
   output logic [COUNT_W-1:0]       high_count,
   output logic                     history_full,
   output logic                     fixed_alarm,
   output logic                     rise_alarm,
   output logic                     alarm
);

   logic [CNT_W-1:0]         cnt;
   logic [COUNT_W-1:0]       cnt_sat;
   logic                     check;
   logic                     fixed_hit;
   logic                     rise_hit;
   logic signed [DIFF_W-1:0] diff;
   logic signed [DIFF_W-1:0] rise_ext;

   logic                     valid_ff;
   logic                     valid_in;
   logic                     alarm_ff;
   logic                     alarm_in;
   logic                     mvld_ff;
   logic signed [MED_W-1:0]  mval_ff;
   logic [COUNT_W-1:0]       count_ff;
   logic                     full_ff;
   logic                     fixed_ff;
   logic                     rise_ff;

   always_comb begin
      cnt      = CNT_W'($countones(view.high));
      cnt_sat  = (int'(cnt) > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(cnt);
      check    = item.median_vld && view.full;
      diff     = DIFF_W'(view.newest) - DIFF_W'(view.oldest);
      rise_ext = signed'({{(DIFF_W - RISE_W){1'b0}}, cfg.rise});
      fixed_hit = check && (int'(cnt) >= int'(cfg.need));
      rise_hit  = check && (diff >= rise_ext);
   end

   always_comb begin
      valid_in = valid_ff;
      alarm_in = alarm_ff;
      if (load) begin
         valid_in = 1'b1;
         alarm_in = alarm_ff || fixed_hit || rise_hit;
      end else if (ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         alarm_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         alarm_ff <= alarm_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mvld_ff  <= item.median_vld;
         mval_ff  <= item.median_vld ? MED_W'(item.median) : '0;
         count_ff <= cnt_sat;
         full_ff  <= view.full;
         fixed_ff <= fixed_hit;
         rise_ff  <= rise_hit;
      end
   end

   assign valid        = valid_ff;
   assign median_valid = mvld_ff;
   assign median_value = mval_ff;
   assign high_count   = count_ff;
   assign history_full = full_ff;
   assign fixed_alarm  = fixed_ff;
   assign rise_alarm   = rise_ff;
   assign alarm        = alarm_ff;

endmodule

@@ design/median_heat_rise_detector_unit.sv @@
// ----------------------------------------------------------------------------
// median_heat_rise_detector_unit
// Median-filtered fixed-temperature and rate-of-rise heat detector.
// ----------------------------------------------------------------------------
//  channel | ports                          | handshake
//  --------+--------------------------------+-----------------------------
//  req     | req_temperature                | req_valid / req_ready
//  rsp     | rsp_median_valid .. rsp_alarm  | rsp_valid / rsp_ready
//  csr     | csr_index, csr_wdata           | csr_we, no wait
//
//  One word in, one word out: rsp_valid rises once the accepted word has
//  passed through window, history and result registers. A new word is taken
//  every cycle while rsp_ready keeps the pipe from stalling.
//  Synchronous reset clears fills, history valid bits and the alarm latch.
//  A stalled result holds the pipe; up to three words are held in flight.
// ----------------------------------------------------------------------------
`include "median_heat_rise_detector_unit_macros.svh"

module median_heat_rise_detector_unit import mhrd_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_temperature,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_median_valid,
   output logic signed [MED_W-1:0]       rsp_median_value,
   output logic [COUNT_W-1:0]            rsp_high_count,
   output logic                          rsp_history_full,
   output logic                          rsp_fixed_alarm,
   output logic                          rsp_rise_alarm,
   output logic                          rsp_alarm,
   input  logic                          csr_we,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          m_vld_ff;
   logic          m_vld_in;
   logic          c_vld_ff;
   logic          c_vld_in;
   push_type      c_item_ff;
   push_type      push;
   hist_view_type view;
   logic          rsp_free;
   logic          c_go;
   logic          c_free;
   logic          m_go;
   logic          m_free;
   logic          load;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_HIGH_TEMP:  cfg_in.high_temp = signed'(csr_wdata[THR_W-1:0]);
            CSR_HIGH_COUNT: cfg_in.need      = csr_wdata[NEED_W-1:0];
            CSR_RISE:       cfg_in.rise      = csr_wdata[RISE_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.high_temp <= HIGH_TEMP_RESET;
         cfg_ff.need      <= HIGH_COUNT_RESET;
         cfg_ff.rise      <= RISE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign rsp_free  = !rsp_valid || rsp_ready;
   assign c_go      = c_vld_ff && rsp_free;
   assign c_free    = !c_vld_ff || rsp_free;
   assign m_go      = m_vld_ff && c_free;
   assign m_free    = !m_vld_ff || c_free;
   assign req_ready = m_free;
   assign load      = req_valid && m_free;

   always_comb begin
      m_vld_in = load ? 1'b1 : (m_go ? 1'b0 : m_vld_ff);
      c_vld_in = m_go ? 1'b1 : (c_go ? 1'b0 : c_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else begin
         m_vld_ff <= m_vld_in;
         c_vld_ff <= c_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (m_go) begin
         c_item_ff <= push;
      end
   end

   mhrd_window u_window (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .temperature (req_temperature),
      .advance     (m_go),
      .push        (push)
   );

   mhrd_history u_history (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .high_temp (cfg_ff.high_temp),
      .view      (view)
   );

   mhrd_result u_result (
      .clock        (clock),
      .reset        (reset),
      .load         (c_go),
      .item         (c_item_ff),
      .view         (view),
      .cfg          (cfg_ff),
      .ready        (rsp_ready),
      .valid        (rsp_valid),
      .median_valid (rsp_median_valid),
      .median_value (rsp_median_value),
      .high_count   (rsp_high_count),
      .history_full (rsp_history_full),
      .fixed_alarm  (rsp_fixed_alarm),
      .rise_alarm   (rsp_rise_alarm),
      .alarm        (rsp_alarm)
   );

   `MHRD_ASSERT_NOW(a_stall_only_when_full, !req_ready, m_vld_ff && c_vld_ff && rsp_valid && !rsp_ready, "input stalled with room in the pipe")
   `MHRD_ASSERT_NOW(a_hit_needs_full, rsp_valid && (rsp_fixed_alarm || rsp_rise_alarm), rsp_history_full && rsp_median_valid && rsp_alarm, "alarm hit without full history")
   `MHRD_ASSERT_NEXT(a_alarm_sticky, rsp_alarm, rsp_alarm, "alarm latch dropped")

endmodule

@@ tb/median_heat_rise_detector_unit_tb.sv @@
// ----------------------------------------------------------------------------
// median_heat_rise_detector_unit_tb
// Self-checking bench for the median heat rise detector. Samples go in over
// the req channel; a behavioural model of the window median, median history
// and alarm checks predicts every rsp word, which is compared field by field.
// Threshold settings change between bursts while the pipe is empty. Both
// channels idle at random, the receiver holds off for one long stretch, and
// the sender waits for the pipe to drain between bursts.
// ----------------------------------------------------------------------------
module median_heat_rise_detector_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mhrd_pkg::*;

   localparam int LIMIT_CYCLES = 200000;
   localparam int PIPE_SETTLE  = 4;
   localparam int HOLD_LEN     = 90;
   localparam int IDLE_PCT     = 14;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum int {STYLE_WALK, STYLE_CLIMB, STYLE_FALL, STYLE_NOISY} sample_style_type;

   typedef struct packed {
      logic             median_valid;
      sample_type       median_value;
      logic [COUNT_W-1:0] high_count;
      logic             history_full;
      logic             fixed_alarm;
      logic             rise_alarm;
      logic             alarm;
   } heat_verdict_type;

   logic                          clock           = 1'b0;
   logic                          reset           = 1'b1;
   logic                          req_valid       = 1'b0;
   logic                          req_ready;
   logic signed [SAMPLE_BITS-1:0] req_temperature = '0;
   logic                          rsp_valid;
   logic                          rsp_ready       = 1'b0;
   logic                          rsp_median_valid;
   logic signed [MED_W-1:0]       rsp_median_value;
   logic [COUNT_W-1:0]            rsp_high_count;
   logic                          rsp_history_full;
   logic                          rsp_fixed_alarm;
   logic                          rsp_rise_alarm;
   logic                          rsp_alarm;
   logic                          csr_we          = 1'b0;
   logic [CSR_IDX_W-1:0]          csr_index       = '0;
   logic [CSR_DATA_W-1:0]         csr_wdata       = '0;

   // model state
   sample_type              window_taps [MEDIAN_TAPS];
   int                      window_fill = 0;
   sample_type              median_log [HISTORY_DEPTH];
   int                      log_fill    = 0;
   logic                    alarm_held  = 1'b0;
   logic signed [THR_W-1:0] thr_cfg     = HIGH_TEMP_RESET;
   logic [NEED_W-1:0]       need_cfg    = HIGH_COUNT_RESET;
   logic [RISE_W-1:0]       rise_cfg    = RISE_RESET;

   heat_verdict_type pending_verdicts [$];

   int  mismatches       = 0;
   int  samples_sent     = 0;
   int  verdicts_checked = 0;
   int  fixed_hits       = 0;
   int  rise_hits        = 0;
   int  settings_made    = 0;
   int  cycle_count      = 0;
   int  walk_level       = 0;
   bit  idle_on          = 1'b1;
   int  hold_asks        = 0;
   int  hold_taken       = 0;
   int  hold_left        = 0;

   median_heat_rise_detector_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_temperature  (req_temperature),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_median_valid (rsp_median_valid),
      .rsp_median_value (rsp_median_value),
      .rsp_high_count   (rsp_high_count),
      .rsp_history_full (rsp_history_full),
      .rsp_fixed_alarm  (rsp_fixed_alarm),
      .rsp_rise_alarm   (rsp_rise_alarm),
      .rsp_alarm        (rsp_alarm),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d words outstanding", cycle_count,
                  pending_verdicts.size());
         $display("median_heat_rise_detector_unit verification failed");
         $finish;
      end
   end

   // receiver: random stalls plus one requested long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (hold_asks != hold_taken) begin
         hold_taken = hold_asks;
         hold_left  = HOLD_LEN - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
      end
   end

   function automatic heat_verdict_type predict_heat_verdict(sample_type t);
      heat_verdict_type v;
      sample_type       sorted [MEDIAN_TAPS];
      sample_type       key;
      int               i;
      int               j;
      int               count;
      int               rise_gap;
      v = '0;
      for (i = MEDIAN_TAPS - 1; i > 0; i--) window_taps[i] = window_taps[i-1];
      window_taps[0] = t;
      if (window_fill < MEDIAN_TAPS) window_fill++;
      if (window_fill >= MEDIAN_TAPS) begin
         sorted = window_taps;
         for (i = 1; i < MEDIAN_TAPS; i++) begin
            key = sorted[i];
            j   = i - 1;
            while (j >= 0 && sorted[j] > key) begin
               sorted[j+1] = sorted[j];
               j--;
            end
            sorted[j+1] = key;
         end
         v.median_valid = 1'b1;
         v.median_value = sorted[(MEDIAN_TAPS - 1) / 2];
         for (i = HISTORY_DEPTH - 1; i > 0; i--) median_log[i] = median_log[i-1];
         median_log[0] = v.median_value;
         if (log_fill < HISTORY_DEPTH) log_fill++;
      end
      count = 0;
      for (i = 0; i < log_fill; i++)
         if (median_log[i] >= thr_cfg) count++;
      v.history_full = (log_fill >= HISTORY_DEPTH);
      if (v.median_valid && v.history_full) begin
         rise_gap      = int'(median_log[0]) - int'(median_log[HISTORY_DEPTH-1]);
         v.fixed_alarm = (count >= int'(need_cfg));
         v.rise_alarm  = (rise_gap >= int'(rise_cfg));
         if (v.fixed_alarm) fixed_hits++;
         if (v.rise_alarm) rise_hits++;
         if (v.fixed_alarm || v.rise_alarm) alarm_held = 1'b1;
      end
      v.high_count = (count > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(count);
      v.alarm      = alarm_held;
      return v;
   endfunction

   function automatic void check_field(string field, logic signed [31:0] want,
                                       logic signed [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d got %0d", $time, field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      heat_verdict_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: result word with nothing pending", $time);
            mismatches++;
         end else begin
            want = pending_verdicts.pop_front();
            check_field("median_valid", want.median_valid, rsp_median_valid);
            check_field("median_value", want.median_value, rsp_median_value);
            check_field("high_count", want.high_count, rsp_high_count);
            check_field("history_full", want.history_full, rsp_history_full);
            check_field("fixed_alarm", want.fixed_alarm, rsp_fixed_alarm);
            check_field("rise_alarm", want.rise_alarm, rsp_rise_alarm);
            check_field("alarm", want.alarm, rsp_alarm);
            verdicts_checked++;
         end
      end
   end

   task automatic send_temp(input sample_type t);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_temperature <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_verdicts.push_back(predict_heat_verdict(t));
      samples_sent++;
   endtask

   task automatic drain_pipe();
      if (req_valid) req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_HIGH_TEMP:  thr_cfg  = data[THR_W-1:0];
         CSR_HIGH_COUNT: need_cfg = data[NEED_W-1:0];
         CSR_RISE:       rise_cfg = data[RISE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_thresholds(input logic signed [THR_W-1:0] thr,
                                 input logic [CSR_DATA_W-1:0] need_word,
                                 input logic [RISE_W-1:0] rise);
      drain_pipe();
      write_csr(CSR_HIGH_TEMP, thr);
      write_csr(CSR_HIGH_COUNT, need_word);
      write_csr(CSR_RISE, rise);
      write_csr(CSR_SPARE, CSR_DATA_W'($urandom));
      csr_we <= 1'b0;
      settings_made++;
   endtask

   function automatic sample_type next_sample(sample_style_type style);
      sample_type s;
      int         pick;
      int         step;
      pick = $urandom_range(99);
      if (pick < 3) begin
         case ($urandom_range(2))
            0:       s = sample_type'(32767);
            1:       s = sample_type'(-32768);
            default: s = sample_type'(-999);
         endcase
      end else if (pick < ((style == STYLE_NOISY) ? 40 : 6)) begin
         s = sample_type'($urandom);
      end else begin
         case (style)
            STYLE_CLIMB: step = $urandom_range(3);
            STYLE_FALL:  step = -int'($urandom_range(3));
            default:     step = int'($urandom_range(8)) - 4;
         endcase
         walk_level += step;
         if (walk_level > 32767) walk_level = 32767;
         if (walk_level < -32768) walk_level = -32768;
         s = sample_type'(walk_level);
      end
      return s;
   endfunction

   // reset thresholds; window filling with extreme and marker-like samples
   task automatic test_window_fill();
      int opening [17] = '{32767, -32768, -999, 0, -1, 1, 58, 57, 59, -999, -999,
                           -999, 32767, 32767, -32768, 21845, -21846};
      foreach (opening[k]) send_temp(sample_type'(opening[k]));
      drain_pipe();
   endtask

   // history fills with checks that cannot trip; over-wide count word
   task automatic test_quiet_history();
      set_thresholds(16'sd58, 16'hFFFF, 16'hFFFF);
      walk_level = 20;
      repeat (40) send_temp(next_sample(STYLE_WALK));
      drain_pipe();
   endtask

   task automatic test_zero_need();
      set_thresholds(16'sd58, 16'd0, 16'hFFFF);
      repeat (10) send_temp(next_sample(STYLE_WALK));
      drain_pipe();
   endtask

   // full-scale rise, then a full-scale fall against a zero rise threshold
   task automatic test_extreme_rise();
      set_thresholds(16'sh8000, 16'd30, 16'hFFFF);
      repeat (35) send_temp(sample_type'(-32768));
      repeat (5) send_temp(sample_type'(32767));
      set_thresholds(16'sh7FFF, 16'd1, 16'd0);
      repeat (8) send_temp(sample_type'(32767));
      repeat (6) send_temp(sample_type'(-32768));
      drain_pipe();
   endtask

   task automatic test_backpressure();
      idle_on    = 1'b0;
      walk_level = 0;
      hold_asks++;
      repeat (60) send_temp(next_sample(STYLE_CLIMB));
      idle_on = 1'b1;
      drain_pipe();
      repeat (20) send_temp(next_sample(STYLE_WALK));
      drain_pipe();
   endtask

   task automatic run_random_phase(input int items, input bit quiet);
      sample_style_type        style;
      logic signed [THR_W-1:0] thr;
      logic [CSR_DATA_W-1:0]   need_word;
      logic [RISE_W-1:0]       rise;
      style = sample_style_type'($urandom_range(3));
      if ($urandom_range(1)) walk_level = int'($urandom_range(400)) - 200;
      else walk_level = int'(sample_type'($urandom));
      case ($urandom_range(5))
         0:       thr = 16'sh8000;
         1:       thr = 16'sh7FFF;
         2:       thr = THR_W'($urandom);
         default: thr = THR_W'(walk_level + int'($urandom_range(40)) - 20);
      endcase
      need_word = {(CSR_DATA_W - NEED_W)'($urandom), NEED_W'($urandom_range(31))};
      case ($urandom_range(4))
         0:       rise = '0;
         1:       rise = '1;
         2:       rise = RISE_W'($urandom);
         default: rise = RISE_W'($urandom_range(40));
      endcase
      set_thresholds(thr, need_word, rise);
      idle_on = !quiet;
      repeat (items) send_temp(next_sample(style));
      drain_pipe();
      idle_on = 1'b1;
   endtask

   task automatic test_random_runs();
      for (int p = 0; p < 12; p++) run_random_phase(115, p == 4);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_window_fill();
      test_quiet_history();
      test_zero_need();
      test_extreme_rise();
      test_backpressure();
      test_random_runs();
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Sent %0d samples, checked %0d result words over %0d threshold settings",
               samples_sent, verdicts_checked, settings_made);
      $display("High-count hits %0d, rise hits %0d, %0d mismatching fields",
               fixed_hits, rise_hits, mismatches);
      if (mismatches == 0)
         $display("median_heat_rise_detector_unit verification clean");
      else
         $display("median_heat_rise_detector_unit verification failed");
      $finish;
   end

endmodule

@@ median_heat_rise_detector_unit.f @@
+incdir+design
design/mhrd_pkg.sv
design/mhrd_window.sv
design/mhrd_history.sv
design/mhrd_result.sv
design/median_heat_rise_detector_unit.sv
tb/median_heat_rise_detector_unit_tb.sv
